// ===== hdl/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared widths, entry layout and request/response types of the LFU cache.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int ENTRIES    = 16;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int CNT_W      = IDX_W + 1;
   localparam int RANK_W     = IDX_W;
   localparam int COUNT_BITS = 16;
   localparam int KEY_W      = 32;
   localparam int VAL_W      = 31;
   localparam int CAP_W      = 5;
   localparam int CMP_W      = 8;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_SET = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0]      key;
      logic [VAL_W-1:0]      value;
      logic [COUNT_BITS-1:0] count;
      logic [RANK_W-1:0]     rank;
   } entry_type;

   typedef struct packed {
      logic             opcode;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic             hit;
      logic [VAL_W-1:0] value;
   } rsp_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== hdl/lfu_ram.sv =====
// ----------------------------------------------------------------------------
// lfu_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hdl/lfu_engine.sv =====
// ----------------------------------------------------------------------------
// lfu_engine
// Scan pass for lookup and victim search, then read-modify-write pass that
// updates counts, ranks and the inserted entry in the entry memory.
// ----------------------------------------------------------------------------
module lfu_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  lfu_pkg::req_type      req,
   input  logic [lfu_pkg::CAP_W-1:0] capacity,
   output logic                  ready,
   output logic                  done_valid,
   input  logic                  done_ready,
   output lfu_pkg::rsp_type      result,
   output logic                  mem_wr_en,
   output logic [lfu_pkg::IDX_W-1:0] mem_wr_addr,
   output lfu_pkg::entry_type    mem_wr_data,
   output logic                  mem_rd_en,
   output logic [lfu_pkg::IDX_W-1:0] mem_rd_addr,
   input  lfu_pkg::entry_type    mem_rd_data
);
   import lfu_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   state_type state_ff, state_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic pv_ff, pv_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;
   req_type req_ff, req_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic found_ff, found_in;
   logic [IDX_W-1:0] hidx_ff, hidx_in;
   entry_type hent_ff, hent_in;
   logic vfound_ff, vfound_in;
   logic [IDX_W-1:0] vidx_ff, vidx_in;
   entry_type vent_ff, vent_in;
   logic ins_ff, ins_in;
   logic evict_ff, evict_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   rsp_type result_ff, result_in;

   logic [CAP_W-1:0] cap_eff;
   logic do_evict;
   logic [ENTRIES-1:0] free_mask;
   logic slot_found;
   logic [IDX_W-1:0] slot_sel;
   logic issue;
   logic rd_vld;
   entry_type upd;

   assign cap_eff = (CMP_W'(capacity) > CMP_W'(ENTRIES)) ? CAP_W'(ENTRIES) : capacity;
   assign do_evict = (req_ff.opcode == OP_SET) && !found_ff && (cap_eff != '0)
                     && (CMP_W'(used_ff) >= CMP_W'(cap_eff));
   assign issue = ((state_ff == ST_SCAN) || (state_ff == ST_UPDATE))
                  && (CMP_W'(cnt_ff) < CMP_W'(ENTRIES));
   assign rd_vld = valid_ff[pidx_ff];

   always_comb begin
      free_mask = ~valid_ff;
      if (do_evict) begin
         free_mask[vidx_ff] = 1'b1;
      end
      slot_found = 1'b0;
      slot_sel = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (free_mask[i] && !slot_found) begin
            slot_found = 1'b1;
            slot_sel = IDX_W'(i);
         end
      end
   end

   assign ready = (state_ff == ST_IDLE);
   assign done_valid = (state_ff == ST_DONE);
   assign result = result_ff;
   assign mem_rd_en = issue;
   assign mem_rd_addr = cnt_ff[IDX_W-1:0];
   assign mem_wr_addr = pidx_ff;
   assign mem_wr_data = upd;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      cnt_in = cnt_ff;
      pv_in = issue;
      pidx_in = cnt_ff[IDX_W-1:0];
      req_in = req_ff;
      used_in = used_ff;
      found_in = found_ff;
      hidx_in = hidx_ff;
      hent_in = hent_ff;
      vfound_in = vfound_ff;
      vidx_in = vidx_ff;
      vent_in = vent_ff;
      ins_in = ins_ff;
      evict_in = evict_ff;
      slot_in = slot_ff;
      result_in = result_ff;
      mem_wr_en = 1'b0;
      upd = mem_rd_data;
      if (issue) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req;
               used_in = '0;
               found_in = 1'b0;
               vfound_in = 1'b0;
               cnt_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (pv_ff) begin
               if (rd_vld) begin
                  used_in = used_ff + CNT_W'(1);
                  if (mem_rd_data.key == req_ff.key) begin
                     found_in = 1'b1;
                     hidx_in = pidx_ff;
                     hent_in = mem_rd_data;
                  end
                  if (!vfound_ff || (mem_rd_data.count < vent_ff.count)
                      || ((mem_rd_data.count == vent_ff.count)
                          && (mem_rd_data.rank > vent_ff.rank))) begin
                     vfound_in = 1'b1;
                     vidx_in = pidx_ff;
                     vent_in = mem_rd_data;
                  end
               end
               if (pidx_ff == LAST_IDX) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            result_in.hit = found_ff;
            result_in.value = ((req_ff.opcode == OP_GET) && found_ff) ? hent_ff.value : '0;
            ins_in = (req_ff.opcode == OP_SET) && !found_ff;
            evict_in = do_evict;
            slot_in = slot_sel;
            cnt_in = '0;
            if (((req_ff.opcode == OP_GET) && found_ff)
                || ((req_ff.opcode == OP_SET) && (cap_eff != '0)
                    && (found_ff || slot_found))) begin
               state_in = ST_UPDATE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_UPDATE: begin
            if (pv_ff) begin
               if (ins_ff) begin
                  if (pidx_ff == slot_ff) begin
                     mem_wr_en = 1'b1;
                     upd.key = req_ff.key;
                     upd.value = req_ff.value;
                     upd.count = COUNT_BITS'(1);
                     upd.rank = '0;
                  end else if (rd_vld && !(evict_ff && (pidx_ff == vidx_ff))) begin
                     mem_wr_en = 1'b1;
                     upd.rank = mem_rd_data.rank + RANK_W'(1)
                        - ((evict_ff && (mem_rd_data.rank > vent_ff.rank))
                           ? RANK_W'(1) : RANK_W'(0));
                  end
               end else begin
                  if (pidx_ff == hidx_ff) begin
                     mem_wr_en = 1'b1;
                     if (req_ff.opcode == OP_SET) begin
                        upd.value = req_ff.value;
                     end
                     if (mem_rd_data.count != '1) begin
                        upd.count = mem_rd_data.count + COUNT_BITS'(1);
                     end
                     upd.rank = '0;
                  end else if (rd_vld && (mem_rd_data.rank < hent_ff.rank)) begin
                     mem_wr_en = 1'b1;
                     upd.rank = mem_rd_data.rank + RANK_W'(1);
                  end
               end
               if (pidx_ff == LAST_IDX) begin
                  if (ins_ff) begin
                     if (evict_ff) begin
                        valid_in[vidx_ff] = 1'b0;
                     end
                     valid_in[slot_ff] = 1'b1;
                  end
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (done_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         cnt_ff <= '0;
         pv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         cnt_ff <= cnt_in;
         pv_ff <= pv_in;
      end
      pidx_ff <= pidx_in;
      req_ff <= req_in;
      used_ff <= used_in;
      found_ff <= found_in;
      hidx_ff <= hidx_in;
      hent_ff <= hent_in;
      vfound_ff <= vfound_in;
      vidx_ff <= vidx_in;
      vent_ff <= vent_in;
      ins_ff <= ins_in;
      evict_ff <= evict_in;
      slot_ff <= slot_in;
      result_ff <= result_in;
   end

endmodule

// ===== hdl/lfu_cache_lru_tiebreak_core.sv =====
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak_core
// Fully associative key-value cache, LFU replacement with LRU tie break.
// ----------------------------------------------------------------------------
// One request at a time. A get miss or a set with capacity zero makes one pass
// of ENTRIES reads over the single-read-port entry memory (a lookup and victim
// scan); any request that changes state makes a second, read-modify-write pass
// of counts and ranks. The response sits in an output register, so the next
// request is taken while it waits.
module lfu_cache_lru_tiebreak_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // key[31:0], write_value[62:32], zero
   input  logic [0:0]  req_tuser,   // opcode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // read_value[30:0], zero
   output logic [0:0]  rsp_tuser,   // hit[0]
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data  // capacity
);
   import lfu_pkg::*;

   logic [CAP_W-1:0] capacity_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   req_type req;
   rsp_type result;
   logic done_valid, done_ready;
   logic wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   entry_type wr_data, rd_data;

   assign req.opcode = req_tuser[0];
   assign req.key = req_tdata[KEY_W-1:0];
   assign req.value = req_tdata[KEY_W+VAL_W-1:KEY_W];

   lfu_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (req_tvalid),
      .req         (req),
      .capacity    (capacity_ff),
      .ready       (req_tready),
      .done_valid  (done_valid),
      .done_ready  (done_ready),
      .result      (result),
      .mem_wr_en   (wr_en),
      .mem_wr_addr (wr_addr),
      .mem_wr_data (wr_data),
      .mem_rd_en   (rd_en),
      .mem_rd_addr (rd_addr),
      .mem_rd_data (rd_data)
   );

   lfu_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign done_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_W'(ENTRIES);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {1'b0, rsp_ff.value};
   assign rsp_tuser = rsp_ff.hit;

endmodule

// ===== hdl/lfu_checker.sv =====
// ----------------------------------------------------------------------------
// lfu_checker
// Port-level checks of the LFU cache core, bound to the top level.
// ----------------------------------------------------------------------------
module lfu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[31])
      else $error("pad bit set");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 32'd0)
      else $error("miss returned data");

endmodule

bind lfu_cache_lru_tiebreak_core lfu_checker u_lfu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== verif/tb_lfu_cache_lru_tiebreak_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lfu_cache_lru_tiebreak_core
// Drives get and set requests into the LFU cache under several capacities,
// with random stalls on both streams, and checks every response against a
// cycle-free model of the cache with least-recently-used tie breaking.
// ----------------------------------------------------------------------------
module tb_lfu_cache_lru_tiebreak_core;
   import lfu_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_SAT = '1;
   localparam int TIMEOUT_CYCLES = 1500000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_wr_en;
   logic [4:0]  csr_wr_data;

   lfu_cache_lru_tiebreak_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // cache mirror
   logic [CAP_W-1:0]      cache_capacity;
   logic                  mir_valid [ENTRIES];
   logic [KEY_W-1:0]      mir_key   [ENTRIES];
   logic [VAL_W-1:0]      mir_data  [ENTRIES];
   logic [COUNT_BITS-1:0] mir_count [ENTRIES];
   int unsigned           mir_rank  [ENTRIES];

   rsp_type     pending_rsp[$];
   int          error_count;
   int          request_count;
   int          response_count;
   int          hit_count;
   longint      cycle_count;
   bit          stall_enable;
   logic [KEY_W-1:0] key_pool[8];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("lfu_cache_lru_tiebreak_core test failed");
         $finish;
      end
   end

   function automatic void mirror_touch(input int e);
      int unsigned old_rank;
      old_rank = mir_rank[e];
      for (int i = 0; i < ENTRIES; i++)
         if (mir_valid[i] && i != e && mir_rank[i] < old_rank) mir_rank[i]++;
      mir_rank[e] = 0;
      if (mir_count[e] != COUNT_SAT) mir_count[e]++;
   endfunction

   function automatic void mirror_evict();
      int v;
      v = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (!mir_valid[i]) continue;
         if (v < 0 || mir_count[i] < mir_count[v] ||
             (mir_count[i] == mir_count[v] && mir_rank[i] > mir_rank[v]))
            v = i;
      end
      if (v >= 0) begin
         mir_valid[v] = 1'b0;
         for (int i = 0; i < ENTRIES; i++)
            if (mir_valid[i] && mir_rank[i] > mir_rank[v]) mir_rank[i]--;
      end
   endfunction

   function automatic rsp_type cache_lookup_update(input req_type rq);
      rsp_type r;
      int e, used, slot, cap;
      e = -1;
      used = 0;
      slot = -1;
      cap = (cache_capacity > ENTRIES) ? ENTRIES : cache_capacity;
      for (int i = 0; i < ENTRIES; i++)
         if (e < 0 && mir_valid[i] && mir_key[i] == rq.key) e = i;
      r.hit = (e >= 0);
      r.value = '0;
      if (rq.opcode == OP_GET) begin
         if (e >= 0) begin
            mirror_touch(e);
            r.value = mir_data[e];
         end
      end else if (cap != 0) begin
         if (e >= 0) begin
            mir_data[e] = rq.value;
            mirror_touch(e);
         end else begin
            for (int i = 0; i < ENTRIES; i++) if (mir_valid[i]) used++;
            if (used >= cap) mirror_evict();
            for (int i = 0; i < ENTRIES; i++) begin
               if (mir_valid[i]) mir_rank[i]++;
               else if (slot < 0) slot = i;
            end
            if (slot >= 0) begin
               mir_valid[slot] = 1'b1;
               mir_key[slot] = rq.key;
               mir_data[slot] = rq.value;
               mir_count[slot] = 1;
               mir_rank[slot] = 0;
            end
         end
      end
      return r;
   endfunction

   task automatic send_request(input logic op, input logic [KEY_W-1:0] k,
                               input logic [VAL_W-1:0] v);
      req_type rq;
      int gap;
      rq.opcode = op;
      rq.key = k;
      rq.value = v;
      if (stall_enable && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, v, k};
      req_tuser <= op;
      do @(posedge clock); while (!req_tready);
      pending_rsp.push_back(cache_lookup_update(rq));
      request_count++;
   endtask

   // response checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         response_count++;
         if (pending_rsp.size() == 0) begin
            $error("unexpected response hit=%0d read_value=%0h",
                   rsp_tuser[0], rsp_tdata[30:0]);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tuser[0] !== want.hit) begin
               $error("hit: expected %0d actual %0d", want.hit, rsp_tuser[0]);
               error_count++;
            end
            if (rsp_tdata[30:0] !== want.value) begin
               $error("read_value: expected %0h actual %0h", want.value,
                      rsp_tdata[30:0]);
               error_count++;
            end
            if (want.hit) hit_count++;
         end
      end
   end

   // receiver stalls in bursts
   initial begin
      int burst;
      rsp_tready = 1'b1;
      forever begin
         @(posedge clock);
         if (stall_enable && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 17);
            rsp_tready <= 1'b0;
            repeat (burst) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [CAP_W-1:0] cap);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cache_capacity = cap;
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   task automatic test_directed();
      send_request(OP_GET, 32'h0, 31'h0);
      send_request(OP_SET, 32'h0, 31'h7FFF_FFFF);
      send_request(OP_GET, 32'h0, 31'h0);
      send_request(OP_SET, 32'hFFFF_FFFF, 31'h0);
      send_request(OP_SET, 32'h8000_0000, 31'h5555_5555);
      send_request(OP_SET, 32'h7FFF_FFFF, 31'h2AAA_AAAA);
      send_request(OP_GET, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
      send_request(OP_GET, 32'h8000_0000, 31'h0);
      send_request(OP_SET, 32'h0, 31'h1234_5678);
      send_request(OP_GET, 32'h1, 31'h0);
      // fill to capacity, then force evictions and tie breaks
      for (int i = 0; i < 14; i++) send_request(OP_SET, 32'h100 + i, VAL_W'(i));
      send_request(OP_SET, 32'hABCD_0000, 31'h1);
   endtask

   task automatic test_capacity_zero();
      set_capacity(5'd0);
      send_request(OP_SET, 32'h0, 31'h1);
      send_request(OP_SET, 32'h4242, 31'h2);
      send_request(OP_GET, 32'h0, 31'h0);
      send_request(OP_GET, 32'h4242, 31'h0);
   endtask

   task automatic test_shrink();
      set_capacity(5'd16);
      for (int i = 0; i < 16; i++) send_request(OP_SET, 32'h200 + i, VAL_W'(i));
      set_capacity(5'd3);
      for (int i = 0; i < 6; i++) send_request(OP_SET, 32'h300 + i, VAL_W'(i));
      for (int i = 0; i < 16; i++) send_request(OP_GET, 32'h200 + i, 31'h0);
   endtask

   task automatic test_random(input int n);
      logic [KEY_W-1:0] k;
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
      for (int i = 0; i < n; i++) begin
         k = pick_key();
         send_request(1'($urandom_range(0, 1)), k, VAL_W'($urandom));
      end
   endtask

   task automatic test_capacities();
      logic [CAP_W-1:0] caps[6] = '{5'd1, 5'd31, 5'd2, 5'd16, 5'd17, 5'd5};
      foreach (caps[c]) begin
         set_capacity(caps[c]);
         test_random(150);
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      cycle_count = 0;
      error_count = 0;
      request_count = 0;
      response_count = 0;
      hit_count = 0;
      stall_enable = 1'b1;
      cache_capacity = 5'd16;
      for (int i = 0; i < ENTRIES; i++) begin
         mir_valid[i] = 1'b0;
         mir_key[i] = '0;
         mir_data[i] = '0;
         mir_count[i] = '0;
         mir_rank[i] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_capacity_zero();
      test_shrink();
      test_capacities();
      set_capacity(5'd8);
      test_random(250);
      stall_enable = 1'b0;
      test_random(100);
      drain();
      $display("Sent %0d requests, checked %0d responses (%0d hits)",
               request_count, response_count, hit_count);
      $display("Capacities covered: 0, 1, 2, 3, 5, 8, 16, 17, 31");
      if (error_count == 0) begin
         $display("lfu_cache_lru_tiebreak_core test passed");
      end else begin
         $display("lfu_cache_lru_tiebreak_core test failed");
      end
      $finish;
   end

endmodule
